@@ src/egb_pkg.sv @@
package egb_pkg;

	localparam int GRID_DIM    = 256;
	localparam int MAX_CELLS   = 64;
	localparam int COORD_WIDTH = 32;

	// Coordinates are taken from the low CIN_W bits of each field
	localparam int CIN_W  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int IDX_W  = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int CNT_W  = $clog2(MAX_CELLS + 2);
	localparam int N_W    = $clog2(MAX_CELLS + 1);
	localparam int SPAN_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
	localparam int CFG_IDX_W = 3;

	typedef struct packed {
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic signed [31:0] node_z;
		logic        [31:0] element_id;
		logic               last_node;
	} node_t;

	typedef struct packed {
		logic [31:0] cell_element;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [7:0]  cell_z;
		logic        last_cell;
		logic        truncated;
	} cell_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_INV_CELL_X = 3'd3,
		REG_INV_CELL_Y = 3'd4,
		REG_INV_CELL_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CRN_MIN_X = 3'd0,
		CRN_MIN_Y = 3'd1,
		CRN_MIN_Z = 3'd2,
		CRN_MAX_X = 3'd3,
		CRN_MAX_Y = 3'd4,
		CRN_MAX_Z = 3'd5
	} corner_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_CALC,
		ST_PROD1,
		ST_PROD2,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    calc_issue;
		corner_t calc_sel;
		logic    prod1;
		logic    prod2;
		logic    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_last;
	} ctrl_sts_t;

	// Report a cell index through an 8-bit field, modulo 256
	function automatic logic [7:0] idx_to_field(input logic [IDX_W-1:0] v);
		logic [IDX_W+7:0] t;
		t = {8'b0, v};
		return t[7:0];
	endfunction

	function automatic logic signed [31:0] coord_in(input logic [31:0] v);
		return 32'(signed'(v[CIN_W-1:0]));
	endfunction

endpackage

@@ src/egb_ctrl.sv @@
module egb_ctrl
	import egb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      node_valid,
	input  logic      node_last,
	output logic      node_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	localparam int NUM_CORNERS = 6;
	// two pipeline stages follow the last corner issue
	localparam logic [2:0] CALC_END = 3'(NUM_CORNERS + 1);

	state_t     state_q, state_d;
	logic [2:0] calc_cnt_q, calc_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACC;
			calc_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			calc_cnt_q <= calc_cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		calc_cnt_d = calc_cnt_q;
		node_ready = 1'b0;
		cmd        = '0;
		cmd.calc_sel = CRN_MIN_X;
		case (state_q)
			ST_ACC: begin
				node_ready = 1'b1;
				if (node_valid) begin
					cmd.accept = 1'b1;
					if (node_last) begin
						state_d    = ST_CALC;
						calc_cnt_d = '0;
					end
				end
			end
			ST_CALC: begin
				cmd.calc_issue = (calc_cnt_q < 3'(NUM_CORNERS));
				cmd.calc_sel   = corner_t'(calc_cnt_q);
				calc_cnt_d     = calc_cnt_q + 3'd1;
				if (calc_cnt_q == CALC_END) begin
					state_d = ST_PROD1;
				end
			end
			ST_PROD1: begin
				cmd.prod1 = 1'b1;
				state_d   = ST_PROD2;
			end
			ST_PROD2: begin
				cmd.prod2 = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && sts.emit_last) begin
					state_d = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

endmodule

@@ src/egb_datapath.sv @@
module egb_datapath
	import egb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  node_t                node_item,
	input  ctrl_cmd_t            cmd,
	output ctrl_sts_t            sts,
	output logic                 cell_valid,
	input  logic                 cell_ready,
	output cell_t                cell_item
);

	localparam logic [31:0]       GMAX     = 32'(GRID_DIM - 1);
	localparam logic [SPAN_W-1:0] SAT_SPAN = SPAN_W'(MAX_CELLS + 1);
	localparam logic [CNT_W-1:0]  SAT_CNT  = CNT_W'(MAX_CELLS + 1);

	// configuration
	logic signed [31:0] origin_q [3];
	logic        [31:0] inv_q    [3];

	// bounding box and element
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic               first_q;
	logic        [31:0] elem_q;

	// corner index pipeline
	logic               vld_s1, vld_s2;
	logic               neg_s1, neg_s2;
	logic        [1:0]  axis_s1, axis_s2;
	logic               hi_s1, hi_s2;
	logic        [31:0] mag_s1, inv_s1;
	logic        [63:0] prod_s2;

	logic [IDX_W-1:0] lo_q [3];
	logic [IDX_W-1:0] hi_q [3];

	logic [CNT_W-1:0] span   [3];
	logic [CNT_W-1:0] p1_q;
	logic             trunc_q;
	logic [IDX_W-1:0] cur_q  [3];
	logic [N_W-1:0]   n_q;
	logic             out_valid_q;
	cell_t            out_q;

	logic signed [31:0] coord [3];
	logic        [1:0]  sel_axis;
	logic               sel_hi;
	logic signed [31:0] sel_c;
	logic        [32:0] off;
	logic [IDX_W-1:0]   idx_wr;
	logic [2*CNT_W-1:0] p1, p2;
	logic               at_end, last;

	assign coord[0] = coord_in(node_item.node_x);
	assign coord[1] = coord_in(node_item.node_y);
	assign coord[2] = coord_in(node_item.node_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				inv_q[a]    <= 32'd65536;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:   origin_q[0] <= cfg_data;
				REG_ORIGIN_Y:   origin_q[1] <= cfg_data;
				REG_ORIGIN_Z:   origin_q[2] <= cfg_data;
				REG_INV_CELL_X: inv_q[0]    <= cfg_data;
				REG_INV_CELL_Y: inv_q[1]    <= cfg_data;
				REG_INV_CELL_Z: inv_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (cmd.accept) begin
			first_q <= node_item.last_node;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= node_item.element_id;
			for (int a = 0; a < 3; a++) begin
				if (first_q || coord[a] < bmin_q[a]) bmin_q[a] <= coord[a];
				if (first_q || coord[a] > bmax_q[a]) bmax_q[a] <= coord[a];
			end
		end
	end

	// corner select
	always_comb begin
		sel_axis = 2'd0;
		sel_hi   = 1'b0;
		case (cmd.calc_sel)
			CRN_MIN_X: begin sel_axis = 2'd0; sel_hi = 1'b0; end
			CRN_MIN_Y: begin sel_axis = 2'd1; sel_hi = 1'b0; end
			CRN_MIN_Z: begin sel_axis = 2'd2; sel_hi = 1'b0; end
			CRN_MAX_X: begin sel_axis = 2'd0; sel_hi = 1'b1; end
			CRN_MAX_Y: begin sel_axis = 2'd1; sel_hi = 1'b1; end
			CRN_MAX_Z: begin sel_axis = 2'd2; sel_hi = 1'b1; end
			default:   begin sel_axis = 2'd0; sel_hi = 1'b0; end
		endcase
		sel_c = sel_hi ? bmax_q[sel_axis] : bmin_q[sel_axis];
		off   = {sel_c[31], sel_c} - {origin_q[sel_axis][31], origin_q[sel_axis]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.calc_issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= off[32];
		mag_s1  <= off[31:0];
		inv_s1  <= inv_q[sel_axis];
		axis_s1 <= sel_axis;
		hi_s1   <= sel_hi;
		prod_s2 <= {32'b0, mag_s1} * {32'b0, inv_s1};
		neg_s2  <= neg_s1;
		axis_s2 <= axis_s1;
		hi_s2   <= hi_s1;
	end

	// truncate to the integer part and clamp into the grid
	always_comb begin
		if (neg_s2) begin
			idx_wr = '0;
		end else if (prod_s2[63:32] > GMAX) begin
			idx_wr = GMAX[IDX_W-1:0];
		end else begin
			idx_wr = prod_s2[32+IDX_W-1:32];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (hi_s2) hi_q[axis_s2] <= idx_wr;
			else       lo_q[axis_s2] <= idx_wr;
		end
	end

	// spans clipped just above the cell limit
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [SPAN_W-1:0] d;
			d = SPAN_W'(hi_q[a]) - SPAN_W'(lo_q[a]) + SPAN_W'(1);
			span[a] = (d > SAT_SPAN) ? SAT_CNT : d[CNT_W-1:0];
		end
		p1 = {{CNT_W{1'b0}}, span[0]} * {{CNT_W{1'b0}}, span[1]};
		p2 = {{CNT_W{1'b0}}, p1_q} * {{CNT_W{1'b0}}, span[2]};
	end

	always_ff @(posedge clk) begin
		if (cmd.prod1) begin
			p1_q <= (p1 > (2*CNT_W)'(SAT_CNT)) ? SAT_CNT : p1[CNT_W-1:0];
		end
		if (cmd.prod2) begin
			trunc_q <= (p2 > (2*CNT_W)'(MAX_CELLS));
		end
	end

	assign at_end = (cur_q[0] == hi_q[0]) && (cur_q[1] == hi_q[1]) && (cur_q[2] == hi_q[2]);
	assign last   = trunc_q ? (n_q == N_W'(MAX_CELLS - 1)) : at_end;

	// walk x outer, z inner
	always_ff @(posedge clk) begin
		if (cmd.prod2) begin
			for (int a = 0; a < 3; a++) cur_q[a] <= lo_q[a];
			n_q <= '0;
		end else if (cmd.emit) begin
			n_q <= n_q + N_W'(1);
			if (cur_q[2] != hi_q[2]) begin
				cur_q[2] <= cur_q[2] + IDX_W'(1);
			end else begin
				cur_q[2] <= lo_q[2];
				if (cur_q[1] != hi_q[1]) begin
					cur_q[1] <= cur_q[1] + IDX_W'(1);
				end else begin
					cur_q[1] <= lo_q[1];
					cur_q[0] <= cur_q[0] + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (cell_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.cell_element <= elem_q;
			out_q.cell_x       <= idx_to_field(cur_q[0]);
			out_q.cell_y       <= idx_to_field(cur_q[1]);
			out_q.cell_z       <= idx_to_field(cur_q[2]);
			out_q.last_cell    <= last;
			out_q.truncated    <= trunc_q;
		end
	end

	assign sts.out_free  = !out_valid_q || cell_ready;
	assign sts.emit_last = last;
	assign cell_valid    = out_valid_q;
	assign cell_item     = out_q;

endmodule

@@ src/element_grid_binning.sv @@
// Once the final node is taken, the six box corners pass the index pipeline, then
// ST_PROD1 and ST_PROD2 size the box and ST_EMIT presents the first cell request.
// Throughput: nodes are taken one per cycle in ST_ACC; the one shared 32x32 multiplier
// walks six box corners; the single output register gives one cell a cycle unless stalled.
// Reset: arst_n clears the controller, the pipeline valids and the output valid flag
// asynchronously and loads the configuration registers with their reset values.
module element_grid_binning
	import egb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 node_valid,
	output logic                 node_ready,
	input  node_t                node_item,
	output logic                 cell_valid,
	input  logic                 cell_ready,
	output cell_t                cell_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Sequencer: take nodes, run corners through the multiplier, size the box,
	// then hand out cells whenever the output register frees up.
	egb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_last  (node_item.last_node),
		.node_ready (node_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Bounding box, corner-to-index pipeline, cell walk and output register.
	// The output register lets the next element's nodes be taken while the
	// last cell request of the previous one still waits.
	egb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.node_item  (node_item),
		.cmd        (cmd),
		.sts        (sts),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_item  (cell_item)
	);

endmodule

@@ src/egb_checker.sv @@
module egb_checker
	import egb_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  node_valid,
	input logic  node_ready,
	input node_t node_item,
	input logic  cell_valid,
	input logic  cell_ready,
	input cell_t cell_item
);

	// a waiting request holds
	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_ready |=> cell_valid && $stable(cell_item))
		else $error("cell request changed while stalled");

	// taking the final node closes the input
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		node_valid && node_ready && node_item.last_node |=> !node_ready)
		else $error("node taken straight after final node");

	// no node is taken while an element is still being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_item.last_cell |-> !node_ready)
		else $error("node taken during cell emission");

	// a cell only follows the final node after the index pipeline has run
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		node_valid && node_ready && node_item.last_node |=> !(cell_valid && !cell_item.last_cell))
		else $error("cell emitted too early");

endmodule

bind element_grid_binning egb_checker u_egb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.node_valid (node_valid),
	.node_ready (node_ready),
	.node_item  (node_item),
	.cell_valid (cell_valid),
	.cell_ready (cell_ready),
	.cell_item  (cell_item)
);

@@ bench/tb_element_grid_binning.sv @@
module tb_element_grid_binning;
	import egb_pkg::*;

	// Index codes with no register behind them: writes here must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Generous bound: every request taking 64 cells behind a stalling receiver
	// fits a few times over
	localparam int CYCLE_LIMIT = 400000;
	// Settling time after the last due cell, with slack
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic node_valid = 1'b0;
	logic node_ready;
	node_t node_item = '0;
	logic cell_valid;
	logic cell_ready = 1'b0;
	cell_t cell_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	element_grid_binning dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_ready (node_ready),
		.node_item  (node_item),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_item  (cell_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// Node requests still to be offered, and cells the grid mapping says must come out
	node_t node_backlog[$];
	cell_t cells_due[$];

	// Own copy of the grid settings, per axis (x, y, z)
	logic signed [31:0] grid_org[3] = '{32'sd0, 32'sd0, 32'sd0};
	logic [31:0] grid_inv[3] = '{32'd65536, 32'd65536, 32'd65536};

	// Own copy of the bounding box being built up
	logic signed [31:0] box_lo[3];
	logic signed [31:0] box_hi[3];
	bit fresh_element = 1'b1;

	int send_idle_pct = 27;
	int recv_idle_pct = 53;
	int fault_count = 0;
	int nodes_queued = 0;
	int nodes_taken = 0;
	int elements_done = 0;
	int trunc_elements = 0;
	int cells_seen = 0;
	int cycle_count = 0;

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 30)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	// Map one coordinate to its cell: offset from the origin times the reciprocal
	// cell size, integer part of the Q32.32 product, clamped to the grid
	function automatic int grid_index(logic signed [31:0] c, logic signed [31:0] org,
			logic [31:0] inv);
		longint off;
		logic [63:0] prod;
		logic [31:0] idx;
		off = longint'(c) - longint'(org);
		if (off < 0)
			return 0;
		prod = {32'b0, off[31:0]} * {32'b0, inv};
		idx = prod[63:32];
		return (idx > GRID_DIM - 1) ? GRID_DIM - 1 : int'(idx);
	endfunction

	// Fold one accepted node into the box; on the final node queue every covered
	// cell, x outer and z inner, cut short at MAX_CELLS
	function automatic void bin_node(node_t n);
		logic signed [31:0] p[3];
		int lo[3];
		int hi[3];
		int unsigned total;
		int limit;
		int count;
		bit trunc;
		cell_t c;
		p[0] = n.node_x;
		p[1] = n.node_y;
		p[2] = n.node_z;
		for (int a = 0; a < 3; a++) begin
			if (fresh_element) begin
				box_lo[a] = p[a];
				box_hi[a] = p[a];
			end else begin
				if (p[a] < box_lo[a])
					box_lo[a] = p[a];
				if (p[a] > box_hi[a])
					box_hi[a] = p[a];
			end
		end
		nodes_taken++;
		fresh_element = n.last_node;
		if (!n.last_node)
			return;
		total = 1;
		for (int a = 0; a < 3; a++) begin
			lo[a] = grid_index(box_lo[a], grid_org[a], grid_inv[a]);
			hi[a] = grid_index(box_hi[a], grid_org[a], grid_inv[a]);
			total = total * (hi[a] - lo[a] + 1);
		end
		trunc = total > MAX_CELLS;
		limit = trunc ? MAX_CELLS : int'(total);
		count = 0;
		for (int ix = lo[0]; ix <= hi[0] && count < limit; ix++)
			for (int iy = lo[1]; iy <= hi[1] && count < limit; iy++)
				for (int iz = lo[2]; iz <= hi[2] && count < limit; iz++) begin
					c.cell_element = n.element_id;
					c.cell_x = 8'(ix);
					c.cell_y = 8'(iy);
					c.cell_z = 8'(iz);
					c.last_cell = (count == limit - 1);
					c.truncated = trunc;
					cells_due.push_back(c);
					count++;
				end
		elements_done++;
		if (trunc)
			trunc_elements++;
	endfunction

	function automatic logic [31:0] fx(int whole, int frac);
		return 32'(whole * 65536 + frac);
	endfunction

	function automatic void push_node(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] id, logic last);
		node_backlog.push_back(node_t'{x, y, z, id, last});
		nodes_queued++;
	endfunction

	// Build one element from the current grid: mostly small boxes a few cells wide,
	// some wide ones that overflow the cell limit, some below the origin and some
	// with raw random coordinates
	function automatic void queue_element();
		int kind;
		int nodes;
		int base[3];
		int span[3];
		logic [31:0] step[3];
		logic [31:0] coord[3];
		logic [31:0] id;
		logic [63:0] q;
		kind = $urandom_range(99);
		nodes = $urandom_range(1, 5);
		id = $urandom;
		for (int a = 0; a < 3; a++) begin
			q = (grid_inv[a] == 0) ? 64'h0100_0000 : 64'h1_0000_0000 / grid_inv[a];
			step[a] = (q > 64'h0100_0000) ? 32'h0100_0000 : q[31:0];
			if (kind >= 12 && kind < 20)
				base[a] = -$urandom_range(1, 6);
			else if ($urandom_range(9) == 0)
				base[a] = $urandom_range(240, 300);
			else
				base[a] = $urandom_range(0, 30);
			span[a] = (kind < 12) ? $urandom_range(3, 9) : $urandom_range(0, 2);
		end
		for (int i = 0; i < nodes; i++) begin
			for (int a = 0; a < 3; a++) begin
				if (kind >= 92)
					coord[a] = $urandom;
				else
					coord[a] = grid_org[a] + step[a] * (base[a] + $urandom_range(span[a]))
						+ $urandom_range(step[a] - 1);
			end
			// Earlier nodes carry junk ids; only the final one counts
			push_node(coord[0], coord[1], coord[2], (i == nodes - 1) ? id : $urandom,
				i == nodes - 1);
		end
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ORIGIN_X: grid_org[0] = val;
			REG_ORIGIN_Y: grid_org[1] = val;
			REG_ORIGIN_Z: grid_org[2] = val;
			REG_INV_CELL_X: grid_inv[0] = val;
			REG_INV_CELL_Y: grid_inv[1] = val;
			REG_INV_CELL_Z: grid_inv[2] = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
		set_reg(REG_ORIGIN_X, ox);
		set_reg(REG_ORIGIN_Y, oy);
		set_reg(REG_ORIGIN_Z, oz);
		set_reg(REG_INV_CELL_X, ix);
		set_reg(REG_INV_CELL_Y, iy);
		set_reg(REG_INV_CELL_Z, iz);
	endtask

	// Hold until every request is taken and every due cell has come out, then let
	// the pipeline settle so the block is truly idle
	task automatic drain();
		while (node_backlog.size() != 0 || node_valid || cells_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: offer the next node whenever the channel is free, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_valid <= 1'b0;
		end else if (!node_valid || node_ready) begin
			if (node_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				node_valid <= 1'b1;
				node_item <= node_backlog.pop_front();
			end else begin
				node_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_ready <= 1'b0;
		end else begin
			cell_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Predict on every node request taken
	always @(posedge clk) begin
		if (arst_n && node_valid && node_ready)
			bin_node(node_item);
	end

	// Compare every cell request taken against the oldest one due
	always @(posedge clk) begin
		cell_t want;
		if (arst_n && cell_valid && cell_ready) begin
			if (cells_due.size() == 0) begin
				report_fault($sformatf("unexpected cell %0h (%0d,%0d,%0d)",
					cell_item.cell_element, cell_item.cell_x, cell_item.cell_y,
					cell_item.cell_z));
			end else begin
				want = cells_due.pop_front();
				if (cell_item.cell_element !== want.cell_element)
					report_fault($sformatf("cell %0d: element %0h, expected %0h", cells_seen,
						cell_item.cell_element, want.cell_element));
				if (cell_item.cell_x !== want.cell_x)
					report_fault($sformatf("cell %0d: x %0d, expected %0d", cells_seen,
						cell_item.cell_x, want.cell_x));
				if (cell_item.cell_y !== want.cell_y)
					report_fault($sformatf("cell %0d: y %0d, expected %0d", cells_seen,
						cell_item.cell_y, want.cell_y));
				if (cell_item.cell_z !== want.cell_z)
					report_fault($sformatf("cell %0d: z %0d, expected %0d", cells_seen,
						cell_item.cell_z, want.cell_z));
				if (cell_item.last_cell !== want.last_cell)
					report_fault($sformatf("cell %0d: last_cell %b, expected %b", cells_seen,
						cell_item.last_cell, want.last_cell));
				if (cell_item.truncated !== want.truncated)
					report_fault($sformatf("cell %0d: truncated %b, expected %b", cells_seen,
						cell_item.truncated, want.truncated));
			end
			cells_seen++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d cells still due", cycle_count,
				cells_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed elements under the reset grid (origin 0, unit cells)
		push_node(fx(0, 0), fx(0, 0), fx(0, 0), 32'h0, 1'b1);
		// Largest coordinates saturate to the top cell, smallest fall below the origin
		push_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
		// Half a cell below the origin, and right at the saturation edge
		push_node(fx(-1, 32768), fx(1, 0), fx(1, 0), 32'h5, 1'b1);
		push_node(fx(255, 65535), fx(256, 0), fx(254, 0), 32'h6, 1'b1);
		// Two nodes, junk id on the first: a 2x1x2 box
		push_node(fx(1, 32768), fx(2, 16384), fx(3, 0), 32'hDEAD_0001, 1'b0);
		push_node(fx(2, 59000), fx(2, 0), fx(4, 65535), 32'h7, 1'b1);
		// Exactly the cell limit, not cut
		push_node(fx(10, 0), fx(10, 0), fx(10, 0), 32'h1, 1'b0);
		push_node(fx(13, 65535), fx(13, 65535), fx(13, 65535), 32'h8, 1'b1);
		// One slice over the limit, cut
		push_node(fx(20, 0), fx(20, 0), fx(20, 0), 32'h1, 1'b0);
		push_node(fx(24, 100), fx(23, 100), fx(23, 100), 32'h9, 1'b1);
		// Whole grid
		push_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h2, 1'b0);
		push_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hA, 1'b1);
		// Later nodes pull the minimum down on different axes
		push_node(fx(5, 0), fx(5, 0), fx(5, 0), 32'h3, 1'b0);
		push_node(fx(3, 0), fx(6, 0), fx(4, 0), 32'h4, 1'b0);
		push_node(fx(4, 0), fx(2, 0), fx(7, 0), 32'hB, 1'b1);
		drain();

		// Offset origin, mixed cell sizes; pause the sender halfway until all is out
		load_grid(fx(-10, 0), fx(5, 32768), fx(100, 0), 32'd131072, 32'd65536, 32'd16384);
		target = nodes_queued + 80;
		while (nodes_queued < target)
			queue_element();
		drain();
		target = nodes_queued + 80;
		while (nodes_queued < target)
			queue_element();
		drain();

		// Extreme settings: origins at both ends, widest, zero and narrowest reciprocal
		send_idle_pct = 53;
		recv_idle_pct = 27;
		load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1);
		set_reg(REG_SPARE_A, $urandom);
		set_reg(REG_SPARE_B, $urandom);
		target = nodes_queued + 160;
		while (nodes_queued < target)
			queue_element();
		drain();

		// Random grid, no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_grid($urandom, $urandom, $urandom, $urandom_range(4096, 1 << 20),
			$urandom_range(4096, 1 << 20), $urandom_range(4096, 1 << 20));
		target = nodes_queued + 160;
		while (nodes_queued < target)
			queue_element();
		drain();

		if (cells_due.size() != 0)
			report_fault($sformatf("%0d cells never came out", cells_due.size()));
		$display("Binned %0d nodes into %0d elements (%0d over the cell limit), %0d cells checked",
			nodes_taken, elements_done, trunc_elements, cells_seen);
		$display("Four grid settings, extremes included, under three idle mixes");
		if (fault_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/egb_pkg.sv
src/egb_ctrl.sv
src/egb_datapath.sv
src/element_grid_binning.sv
src/egb_checker.sv
bench/tb_element_grid_binning.sv
